### sv/pqrl_pkg.sv
// ----------------------------------------------------------------------------
// pqrl_pkg
// shared types and constants for the longest-process removal queue
// ----------------------------------------------------------------------------
package pqrl_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int COUNT_W = 5;
   localparam int ID_W    = 16;
   localparam int TIME_W  = 16;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   proc_id;
      logic [TIME_W-1:0] exec_time;
   } entry_type;

   typedef struct packed {
      logic             vld;
      logic             first;
      logic [IDX_W-1:0] idx;
   } cmp_ctl_type;

endpackage

### sv/pqrl_table.sv
// ----------------------------------------------------------------------------
// pqrl_table
// process table memory, one write and one registered read port
// ----------------------------------------------------------------------------
module pqrl_table
   import pqrl_pkg::*;
(
   input  logic             clock,
   input  logic             we,
   input  logic [IDX_W-1:0] waddr,
   input  entry_type        wdata,
   input  logic [IDX_W-1:0] raddr,
   output entry_type        rdata
);

   entry_type mem_ff [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/pqrl_best.sv
// ----------------------------------------------------------------------------
// pqrl_best
// running maximum of execution time over a scan, earliest entry on ties
// ----------------------------------------------------------------------------
module pqrl_best
   import pqrl_pkg::*;
(
   input  logic             clock,
   input  cmp_ctl_type      ctl,
   input  entry_type        data,
   output logic [IDX_W-1:0] best_idx,
   output entry_type        best_entry
);

   logic [IDX_W-1:0] best_idx_ff;
   entry_type        best_entry_ff;
   logic             take;

   assign take = ctl.vld && (ctl.first || (data.exec_time > best_entry_ff.exec_time));

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff   <= ctl.idx;
         best_entry_ff <= data;
      end
   end

   assign best_idx   = best_idx_ff;
   assign best_entry = best_entry_ff;

endmodule

### sv/process_queue_remove_longest.sv
// ----------------------------------------------------------------------------
// process_queue_remove_longest
// ordered process table with removal of the longest-running entry
// ----------------------------------------------------------------------------
// One word in, one word out, one item at a time; req_stall is high while an
// item is being worked on. Insert and query pass from idle straight to the
// emit state. A remove on a table holding n entries, whose longest entry
// sits at place b, makes n reads to find the maximum, then n - 1 - b
// read/write moves to close the gap, all through the single read port of
// the table memory. A finished word waits in the output register while the
// next item is taken.
module process_queue_remove_longest
   import pqrl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [ID_W-1:0]     req_proc_id,
   input  logic [TIME_W-1:0]   req_exec_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [ID_W-1:0]     rsp_removed_id,
   output logic [TIME_W-1:0]   rsp_removed_time,
   output logic [COUNT_W-1:0]  rsp_count
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_EMIT
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   held_count_ff;
   logic [CNT_W-1:0]   issue_ptr_ff;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   status_type         res_status_ff;
   entry_type          res_entry_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   entry_type          rsp_entry_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic               req_acc;
   logic               full;
   logic               issue;
   logic               pass_done;
   logic               tbl_we;
   logic [IDX_W-1:0]   tbl_waddr;
   entry_type          tbl_wdata;
   entry_type          tbl_rdata;
   cmp_ctl_type        cmp_ctl;
   logic [IDX_W-1:0]   best_idx;
   entry_type          best_entry;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign full      = (held_count_ff >= CNT_W'(DEPTH));
   assign issue     = ((state_ff == S_SCAN) || (state_ff == S_SHIFT))
                      && (issue_ptr_ff < held_count_ff);
   assign pass_done = !issue && !rd_vld_ff;

   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = held_count_ff[IDX_W-1:0];
      tbl_wdata = '{proc_id: req_proc_id, exec_time: req_exec_time};
      if ((state_ff == S_IDLE) && req_acc && (req_mode == MODE_INSERT) && !full) begin
         tbl_we = 1'b1;
      end else if ((state_ff == S_SHIFT) && rd_vld_ff) begin
         tbl_we    = 1'b1;
         tbl_waddr = rd_idx_ff - IDX_W'(1);
         tbl_wdata = tbl_rdata;
      end
   end

   assign cmp_ctl = '{vld: (state_ff == S_SCAN) && rd_vld_ff,
                      first: (rd_idx_ff == '0),
                      idx: rd_idx_ff};

   pqrl_table u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (issue_ptr_ff[IDX_W-1:0]),
      .rdata (tbl_rdata)
   );

   pqrl_best u_best (
      .clock      (clock),
      .ctl        (cmp_ctl),
      .data       (tbl_rdata),
      .best_idx   (best_idx),
      .best_entry (best_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_count_ff <= '0;
         issue_ptr_ff  <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_vld_ff <= issue;
         rd_idx_ff <= issue_ptr_ff[IDX_W-1:0];
         if (issue) begin
            issue_ptr_ff <= issue_ptr_ff + CNT_W'(1);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  res_entry_ff  <= '0;
                  res_status_ff <= ST_DONE;
                  state_ff      <= S_EMIT;
                  unique case (req_mode)
                     MODE_INSERT: begin
                        if (full) begin
                           res_status_ff <= ST_FULL;
                        end else begin
                           held_count_ff <= held_count_ff + CNT_W'(1);
                        end
                     end
                     MODE_REMOVE: begin
                        if (held_count_ff == '0) begin
                           res_status_ff <= ST_EMPTY;
                        end else begin
                           issue_ptr_ff <= '0;
                           state_ff     <= S_SCAN;
                        end
                     end
                     default: begin
                        res_status_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (pass_done) begin
                  issue_ptr_ff <= CNT_W'(best_idx) + CNT_W'(1);
                  state_ff     <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (pass_done) begin
                  held_count_ff <= held_count_ff - CNT_W'(1);
                  res_status_ff <= ST_DONE;
                  res_entry_ff  <= best_entry;
                  state_ff      <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_entry_ff  <= res_entry_ff;
                  rsp_count_ff  <= COUNT_W'(held_count_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_removed_id   = rsp_entry_ff.proc_id;
   assign rsp_removed_time = rsp_entry_ff.exec_time;
   assign rsp_count        = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= CNT_W'(DEPTH))
      else $error("held count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (held_count_ff == $past(held_count_ff)) ||
      (held_count_ff == $past(held_count_ff) + CNT_W'(1)) ||
      (held_count_ff + CNT_W'(1) == $past(held_count_ff)))
      else $error("held count moved by more than one");

   a_remove_scans: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_mode == MODE_REMOVE) && (held_count_ff != '0)) |=>
      (state_ff == S_SCAN))
      else $error("remove on non-empty table did not start a scan");

   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SHIFT) && rd_vld_ff) |-> (rd_idx_ff != '0))
      else $error("shift writes below the table start");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_DONE)) |->
      ((rsp_entry_ff.proc_id == '0) && (rsp_entry_ff.exec_time == '0)))
      else $error("failed item carries a removed entry");

endmodule

### test/process_queue_remove_longest_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_queue_remove_longest_test
// self-checking bench for the longest-process removal queue
// ----------------------------------------------------------------------------
// Drives insert, remove and query words with random gaps and random result
// stalls and keeps its own copy of the process table. From that copy it
// predicts status, removed id/time and count for every accepted word, and
// checks each returned word in order. Directed words cover the empty and
// full table, equal greatest times and the spare mode value. The random part
// sweeps the fill level between empty and full.
// ----------------------------------------------------------------------------
module process_queue_remove_longest_test;
   import pqrl_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int MAX_GAP       = 16;
   localparam int RANDOM_ITEMS  = 1325;
   localparam int LONG_HOLD_AT  = 400;
   localparam int LONG_HOLD     = 300;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

   typedef struct {
      logic [1:0]        mode;
      logic [ID_W-1:0]   proc_id;
      logic [TIME_W-1:0] exec_time;
      int                gap;
      bit                drain;
   } request_type;

   typedef struct {
      status_type         status;
      logic [ID_W-1:0]    removed_id;
      logic [TIME_W-1:0]  removed_time;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_mode = MODE_QUERY;
   logic [ID_W-1:0]     req_proc_id = '0;
   logic [TIME_W-1:0]   req_exec_time = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [ID_W-1:0]     rsp_removed_id;
   logic [TIME_W-1:0]   rsp_removed_time;
   logic [COUNT_W-1:0]  rsp_count;

   request_type pending_words[$];
   outcome_type expected_words[$];

   logic [ID_W-1:0]   slot_id[DEPTH];
   logic [TIME_W-1:0] slot_time[DEPTH];
   int held_count = 0;

   int failures = 0;
   int words_sent = 0;
   int words_checked = 0;
   int removals_done = 0;
   int full_rejects = 0;
   int empty_rejects = 0;
   int gap_left = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   process_queue_remove_longest dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_proc_id      (req_proc_id),
      .req_exec_time    (req_exec_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_removed_id   (rsp_removed_id),
      .rsp_removed_time (rsp_removed_time),
      .rsp_count        (rsp_count)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // work out the word a request produces and update the table copy
   function automatic void predict_outcome(input logic [1:0] mode,
                                           input logic [ID_W-1:0] id,
                                           input logic [TIME_W-1:0] tm);
      outcome_type w;
      int best;
      w.status = ST_DONE;
      w.removed_id = '0;
      w.removed_time = '0;
      case (mode)
         MODE_INSERT: begin
            if (held_count >= DEPTH) begin
               w.status = ST_FULL;
               full_rejects++;
            end else begin
               slot_id[held_count] = id;
               slot_time[held_count] = tm;
               held_count++;
            end
         end
         MODE_REMOVE: begin
            if (held_count == 0) begin
               w.status = ST_EMPTY;
               empty_rejects++;
            end else begin
               best = 0;
               for (int i = 1; i < held_count; i++)
                  if (slot_time[i] > slot_time[best])
                     best = i;
               w.removed_id = slot_id[best];
               w.removed_time = slot_time[best];
               for (int i = best; i + 1 < held_count; i++) begin
                  slot_id[i] = slot_id[i + 1];
                  slot_time[i] = slot_time[i + 1];
               end
               held_count--;
               removals_done++;
            end
         end
         default: ;
      endcase
      w.count = COUNT_W'(held_count);
      expected_words.push_back(w);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at word %0d: %s", words_checked, what);
      failures++;
   endtask

   function automatic int draw_gap(input int index);
      if ((index / 120) % 4 == 3)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void add_word(input logic [1:0] mode, input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] tm, input bit drain);
      request_type r;
      r.mode = mode;
      r.proc_id = id;
      r.exec_time = tm;
      r.gap = draw_gap(pending_words.size());
      r.drain = drain;
      pending_words.push_back(r);
   endfunction

   // driver
   always @(posedge clock) begin
      request_type r;
      bit busy;
      bit drive;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         busy = req_valid;
         drive = 1'b0;
         if (req_valid && !req_stall) begin
            predict_outcome(req_mode, req_proc_id, req_exec_time);
            words_sent++;
            busy = 1'b0;
         end
         if (busy) begin
            drive = 1'b1;
         end else if (pending_words.size() > 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (!(pending_words[0].drain && expected_words.size() > 0)) begin
               r = pending_words.pop_front();
               req_mode <= r.mode;
               req_proc_id <= r.proc_id;
               req_exec_time <= r.exec_time;
               drive = 1'b1;
               gap_left = (pending_words.size() > 0) ? pending_words[0].gap : 0;
            end
         end
         req_valid <= drive;
      end
   end

   // monitor and result-side stalls
   always @(posedge clock) begin
      outcome_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word status %0d count %0d",
                                         rsp_status, rsp_count));
            end else begin
               w = expected_words.pop_front();
               if (rsp_status !== w.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_status, w.status));
               if (rsp_removed_id !== w.removed_id)
                  report_mismatch($sformatf("removed_id %h, want %h",
                                            rsp_removed_id, w.removed_id));
               if (rsp_removed_time !== w.removed_time)
                  report_mismatch($sformatf("removed_time %h, want %h",
                                            rsp_removed_time, w.removed_time));
               if (rsp_count !== w.count)
                  report_mismatch($sformatf("count %0d, want %0d", rsp_count, w.count));
            end
            words_checked++;
            if (words_checked == LONG_HOLD_AT)
               stall_left = LONG_HOLD;
            else if ((words_checked / 150) % 3 == 2)
               stall_left = 0;
            else
               stall_left = $urandom_range(0, MAX_GAP);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int bias;
      bit narrow;
      int pick;
      logic [TIME_W-1:0] tm;

      // directed: empty table, query, spare mode
      add_word(MODE_REMOVE, 16'h1234, 16'h5678, 1'b0);
      add_word(MODE_QUERY, 16'hffff, 16'hffff, 1'b0);
      add_word(MODE_SPARE, 16'hffff, 16'hffff, 1'b0);
      // fill with extremes and equal greatest times
      add_word(MODE_INSERT, 16'h0000, 16'h0000, 1'b0);
      add_word(MODE_INSERT, 16'hffff, 16'hffff, 1'b0);
      add_word(MODE_INSERT, 16'h0001, 16'h7fff, 1'b0);
      add_word(MODE_INSERT, 16'h8000, 16'hffff, 1'b0);
      add_word(MODE_INSERT, 16'haaaa, 16'h5555, 1'b0);
      add_word(MODE_INSERT, 16'h5555, 16'haaaa, 1'b0);
      for (int i = 0; i < 10; i++)
         add_word(MODE_INSERT, ID_W'(16'h0100 + i), TIME_W'(i * 3), 1'b0);
      add_word(MODE_INSERT, 16'hdead, 16'hbeef, 1'b0);
      add_word(MODE_QUERY, 16'h0000, 16'h0000, 1'b0);
      add_word(MODE_REMOVE, 16'h0000, 16'h0000, 1'b0);
      add_word(MODE_REMOVE, 16'hffff, 16'hffff, 1'b0);
      add_word(MODE_REMOVE, 16'h0000, 16'h0000, 1'b0);
      add_word(MODE_INSERT, 16'h0bad, 16'hffff, 1'b0);

      // random: phases biased towards filling, draining or balanced
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 80 == 0) begin
            bias = $urandom_range(0, 2);
            narrow = $urandom_range(0, 2) == 0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 4)
            add_word(MODE_QUERY, ID_W'($urandom), TIME_W'($urandom), n % 500 == 300);
         else if (pick < 7)
            add_word(MODE_SPARE, ID_W'($urandom), TIME_W'($urandom), n % 500 == 300);
         else begin
            if (narrow)
               tm = TIME_W'($urandom_range(0, 3));
            else if ($urandom_range(0, 9) == 0)
               tm = $urandom_range(0, 1) ? '1 : '0;
            else
               tm = TIME_W'($urandom);
            if ($urandom_range(0, 99) < (bias == 0 ? 75 : (bias == 1 ? 25 : 50)))
               add_word(MODE_INSERT, ID_W'($urandom), tm, n % 500 == 300);
            else
               add_word(MODE_REMOVE, ID_W'($urandom), tm, n % 500 == 300);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d words sent, %0d results checked, %0d failures", words_sent,
               words_checked, failures);
      $display("%0d removals, %0d inserts refused full, %0d removes refused empty",
               removals_done, full_rejects, empty_rejects);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
